>>> sv/category_value_dictionary_assert.svh
// ----------------------------------------------------------------------------
// Dictionary assertion macros
// Concurrent check macros clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef CATEGORY_VALUE_DICTIONARY_ASSERT_SVH
`define CATEGORY_VALUE_DICTIONARY_ASSERT_SVH
`ifndef SYNTHESIS
// Implication check: when a holds, c must hold in the same cycle.
`define CVD_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("dictionary check failed");
// Next-cycle check: when a holds, c must hold in the next cycle.
`define CVD_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("dictionary check failed");
// Invariant check: p holds in every cycle out of reset.
`define CVD_ASSERT_INV(lbl, p) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (p)) \
    else $error("dictionary check failed");
`else
`define CVD_ASSERT_IMP(lbl, a, c)
`define CVD_ASSERT_NXT(lbl, a, c)
`define CVD_ASSERT_INV(lbl, p)
`endif
`endif

>>> sv/cvd_pkg.sv
// ----------------------------------------------------------------------------
// Dictionary package
// Shared codes, the search packet that moves down the cell chain, helpers.
// ----------------------------------------------------------------------------
package cvd_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned VwW    = 4;

  // request function codes
  localparam logic [1:0] FuncUpdate = 2'd0;
  localparam logic [1:0] FuncFind   = 2'd1;
  localparam logic [1:0] FuncRead   = 2'd2;

  // configuration register indexes
  localparam logic CfgIsString   = 1'b0;
  localparam logic CfgValueWidth = 1'b1;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  // search packet handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [1:0]        func;
    logic [ValueW-1:0] value;
    logic [ValueW-1:0] mask;
    logic [IdxW-1:0]   idx;
    logic              hit;
    logic [ValueW-1:0] rvalue;
  } pkt_t;

  // compare mask covering the low w bytes; eight or more covers all
  function automatic logic [ValueW-1:0] byte_mask(input logic [VwW-1:0] w);
    logic [ValueW-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      m[b*8 +: 8] = ({1'b0, w} > 5'(b)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

>>> sv/cvd_cell.sv
// ----------------------------------------------------------------------------
// Dictionary cell
// Holds one entry, checks the passing packet against it, hands it on.
// ----------------------------------------------------------------------------
module cvd_cell #(
  parameter int unsigned CellPos = 0,
  parameter int unsigned PosW    = 6,
  parameter int unsigned CntW    = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [CntW-1:0]           count_i,
  input  logic                      wr_en_i,
  input  logic [PosW-1:0]           wr_pos_i,
  input  logic [cvd_pkg::ValueW-1:0] wr_data_i,
  input  cvd_pkg::pkt_t             pkt_i,
  input  logic [PosW-1:0]           pos_i,
  output cvd_pkg::pkt_t             pkt_o,
  output logic [PosW-1:0]           pos_o
);

  localparam int unsigned CmpW = (PosW > cvd_pkg::IdxW) ? PosW : cvd_pkg::IdxW;

  logic [cvd_pkg::ValueW-1:0] entry_q;
  cvd_pkg::pkt_t              pkt_d, pkt_q;
  logic [PosW-1:0]            pos_d, pos_q;
  logic                       filled, is_search, eq;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_pos_i == PosW'(CellPos))) begin
      entry_q <= wr_data_i;
    end
  end

  assign filled    = pkt_i.valid && (CntW'(CellPos) < count_i);
  assign is_search = (pkt_i.func == cvd_pkg::FuncUpdate) || (pkt_i.func == cvd_pkg::FuncFind);
  assign eq        = ((entry_q ^ pkt_i.value) & pkt_i.mask) == '0;

  always_comb begin
    pkt_d = pkt_i;
    pos_d = pos_i;
    // first match wins: later cells leave an earlier hit alone
    if (filled && is_search && !pkt_i.hit && eq) begin
      pkt_d.hit = 1'b1;
      pos_d     = PosW'(CellPos);
    end
    if (filled && (pkt_i.func == cvd_pkg::FuncRead) &&
        (CmpW'(pkt_i.idx) == CmpW'(CellPos))) begin
      pkt_d.hit    = 1'b1;
      pkt_d.rvalue = entry_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q <= '0;
    end else begin
      pkt_q <= pkt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
  end

  assign pkt_o = pkt_q;
  assign pos_o = pos_q;

endmodule

>>> sv/category_value_dictionary.sv
// ----------------------------------------------------------------------------
// Category value dictionary
// Distinct-value table with update, find and read-by-index requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each table entry
// lives in a cell of a chain of MAX_ENTRIES cells; the request travels down
// the chain one cell per cycle, passing the head register, the cells and the
// done register, and then strobes its result on done_o; busy drops in that
// same cycle. A new request can be taken at the edge ending the done_o cycle,
// so the block takes no new request while one is still in the chain. The
// done_o strobe is high for a single cycle and cannot be held off; the result
// outputs hold until the next result. An update that finds no equal entry
// appends the value at index entry_count (string variables only); a full
// table drops it and raises full_drop_o. Two values are equal when their
// lowest value_width bytes match. Write configuration only while busy is low.
`include "category_value_dictionary_assert.svh"

module category_value_dictionary #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  // request side
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [63:0] value_i,
  input  logic [5:0]  index_i,
  // result side
  output logic        done_o,
  output logic        found_o,
  output logic [5:0]  result_index_o,
  output logic        inserted_o,
  output logic        full_drop_o,
  output logic [63:0] result_value_o,
  output logic [6:0]  entry_count_o
);

  localparam int unsigned PosW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);

  cvd_pkg::state_e state_q, state_d;

  logic            is_string_q;
  logic [3:0]      value_width_q;
  logic [CntW-1:0] count_q, count_d;

  cvd_pkg::pkt_t   pkt_chain [MAX_ENTRIES+1];
  logic [PosW-1:0] pos_chain [MAX_ENTRIES+1];
  cvd_pkg::pkt_t   head_d, head_q;

  logic            launch, finish, wr_en, need_ins, room;
  cvd_pkg::pkt_t   tail;
  logic [PosW-1:0] tail_pos;

  logic            done_q, found_q, inserted_q, full_drop_q;
  logic [5:0]      rindex_q, rindex_d;
  logic [63:0]     rvalue_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_string_q   <= 1'b1;
      value_width_q <= 4'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cvd_pkg::CfgIsString:   is_string_q   <= cfg_data_i[0];
        cvd_pkg::CfgValueWidth: value_width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer: next state
  assign tail     = pkt_chain[MAX_ENTRIES];
  assign tail_pos = pos_chain[MAX_ENTRIES];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cvd_pkg::StIdle: if (start) state_d = cvd_pkg::StRun;
      cvd_pkg::StRun:  if (tail.valid) state_d = cvd_pkg::StIdle;
      default:         state_d = cvd_pkg::StIdle;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    busy   = 1'b0;
    launch = 1'b0;
    finish = 1'b0;
    unique case (state_q)
      cvd_pkg::StIdle: launch = start;
      cvd_pkg::StRun: begin
        busy   = 1'b1;
        finish = tail.valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cvd_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // build the search packet from the request and the current mask
  always_comb begin
    head_d        = '0;
    head_d.valid  = launch;
    head_d.func   = func_i;
    head_d.value  = value_i;
    head_d.mask   = cvd_pkg::byte_mask(value_width_q);
    head_d.idx    = index_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  assign pkt_chain[0] = head_q;
  assign pos_chain[0] = '0;

  // the cell chain, one entry per cell
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    cvd_cell #(
      .CellPos (g),
      .PosW    (PosW),
      .CntW    (CntW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .count_i   (count_q),
      .wr_en_i   (wr_en),
      .wr_pos_i  (PosW'(count_q)),
      .wr_data_i (tail.value),
      .pkt_i     (pkt_chain[g]),
      .pos_i     (pos_chain[g]),
      .pkt_o     (pkt_chain[g+1]),
      .pos_o     (pos_chain[g+1])
    );
  end

  // append on a miss of an update for a string variable, if there is room
  assign need_ins = finish && (tail.func == cvd_pkg::FuncUpdate) && !tail.hit && is_string_q;
  assign room     = count_q < CntW'(MAX_ENTRIES);
  assign wr_en    = need_ins && room;
  assign count_d  = wr_en ? CntW'(count_q + 1'b1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // result index: read echoes the index, a hit gives its cell, an append
  // gives the new slot, anything else is zero
  always_comb begin
    if (tail.func == cvd_pkg::FuncRead) begin
      rindex_d = tail.idx;
    end else if (tail.hit) begin
      rindex_d = 6'(tail_pos);
    end else if (wr_en) begin
      rindex_d = 6'(count_q);
    end else begin
      rindex_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= finish;
    end
  end

  // hold result payload from the finishing cycle
  always_ff @(posedge clk_i) begin
    if (finish) begin
      found_q     <= tail.hit;
      rindex_q    <= rindex_d;
      inserted_q  <= wr_en;
      full_drop_q <= need_ins && !room;
      rvalue_q    <= (tail.func == cvd_pkg::FuncRead) ? tail.rvalue : '0;
    end
  end

  assign done_o         = done_q;
  assign found_o        = found_q;
  assign result_index_o = rindex_q;
  assign inserted_o     = inserted_q;
  assign full_drop_o    = full_drop_q;
  assign result_value_o = rvalue_q;
  assign entry_count_o  = 7'(count_q);

  `CVD_ASSERT_INV(a_count_bound, count_q <= CntW'(MAX_ENTRIES))
  `CVD_ASSERT_IMP(a_ins_xor_drop, done_q, !(inserted_q && full_drop_q))
  `CVD_ASSERT_IMP(a_ins_bumps, done_q && inserted_q, count_q == CntW'($past(count_q) + 1'b1))
  `CVD_ASSERT_IMP(a_tail_in_run, tail.valid, state_q == cvd_pkg::StRun)
  `CVD_ASSERT_NXT(a_finish_idle, finish, !busy && done_o)

endmodule
